// ===== hdl/prrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_pkg
// Types and constants shared by the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int ID_W    = 6;
    localparam int TIME_W  = 22;
    localparam int QUANT_W = 16;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;

    // function codes of an input word
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_GRANT = 1'b1;

    // register indexes on the configuration port
    localparam logic REG_QUANTUM = 1'b0;

    // one row of the sorted task table
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    load_id;
    } t_entry;

endpackage

// ===== hdl/prrs_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_table
// Sorted task table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prrs_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  prrs_pkg::t_entry i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output prrs_pkg::t_entry o_rd_data
);
    import prrs_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/priority_round_robin_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// Keeps tasks sorted by priority and grants time slices round robin within
// the highest-priority group that still has work.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  command   in         start, busy                i_func, i_task_priority, i_task_burst
//  result    out        o_result_valid (strobe)    o_task_id, o_start_time,
//                                                  o_slice_length, o_task_finished, o_all_done
//  config    in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
//  a load either appends or shifts rows down when it inserts: every table row is read,
//  for the position search or the shift
//  a grant scans the rows up to the end of the served group, then steps
//  round robin inside that group; a table with no work answers once every
//  row has been scanned
//  loads into a full table are dropped with no result
//  reset clears count, cursor, elapsed time and sets the quantum to 10
//  results are strobed for one cycle and cannot be held off
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler #(
    parameter int MAX_TASKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [prrs_pkg::PRIO_W-1:0]   i_task_priority,
    input  logic [prrs_pkg::BURST_W-1:0]  i_task_burst,
    // result
    output logic                          o_result_valid,
    output logic [prrs_pkg::ID_W-1:0]     o_task_id,
    output logic [prrs_pkg::TIME_W-1:0]   o_start_time,
    output logic [prrs_pkg::BURST_W-1:0]  o_slice_length,
    output logic                          o_task_finished,
    output logic                          o_all_done,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import prrs_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_LD_CHK = 12'b0000_0000_0010,
        S_LD_CMP = 12'b0000_0000_0100,
        S_SH_CHK = 12'b0000_0000_1000,
        S_SH_WR  = 12'b0000_0001_0000,
        S_LD_PUT = 12'b0000_0010_0000,
        S_G1_CHK = 12'b0000_0100_0000,
        S_G1_CMP = 12'b0000_1000_0000,
        S_G2_CHK = 12'b0001_0000_0000,
        S_G2_CMP = 12'b0010_0000_0000,
        S_G3_RD  = 12'b0100_0000_0000,
        S_G3_CMP = 12'b1000_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [QUANT_W-1:0]   r_quantum;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_cursor, n_cursor;
    logic [TIME_W-1:0]    r_elapsed, n_elapsed;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CW-1:0]        r_gs, n_gs;
    logic [CW-1:0]        r_ge, n_ge;
    logic [PRIO_W-1:0]    r_prio, n_prio;
    logic [BURST_W-1:0]   r_burst, n_burst;

    logic                 r_out_valid, n_out_valid;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic [TIME_W-1:0]    r_out_time, n_out_time;
    logic [BURST_W-1:0]   r_out_slice, n_out_slice;
    logic                 r_out_fin, n_out_fin;
    logic                 r_out_done, n_out_done;

    logic                 tbl_wr_en;
    logic [IW-1:0]        tbl_wr_addr;
    t_entry               tbl_wr_data;
    logic [IW-1:0]        tbl_rd_addr;
    t_entry               tbl_rd_data;

    logic                 accept;
    logic                 cfg_wr;
    logic [CW-1:0]        ptr_inc;
    logic [CW-1:0]        ptr_dec;
    logic [CW-1:0]        cursor_ext;
    logic [CW-1:0]        rr_start;
    logic [CW-1:0]        run_start;
    logic [BURST_W-1:0]   slice;

    assign accept     = start && !busy;
    assign busy       = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_QUANTUM) ? {16'd0, r_quantum} : 32'd0;

    assign ptr_inc    = r_ptr + 1'b1;
    assign ptr_dec    = r_ptr - 1'b1;
    assign cursor_ext = CW'(r_cursor);
    // the search starts at the cursor only when it lies inside the group
    assign rr_start   = (cursor_ext >= r_gs && cursor_ext < r_ptr) ? cursor_ext : r_gs;
    assign run_start  = (r_ptr == '0 || tbl_rd_data.prio != r_prio) ? r_ptr : r_gs;
    assign slice      = (tbl_rd_data.burst > r_quantum) ? r_quantum : tbl_rd_data.burst;

    prrs_table #(
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_elapsed   = r_elapsed;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_gs        = r_gs;
        n_ge        = r_ge;
        n_prio      = r_prio;
        n_burst     = r_burst;
        n_out_valid = 1'b0;
        n_out_id    = r_out_id;
        n_out_time  = r_out_time;
        n_out_slice = r_out_slice;
        n_out_fin   = r_out_fin;
        n_out_done  = r_out_done;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = r_ptr[IW-1:0];
        tbl_wr_data = tbl_rd_data;
        tbl_rd_addr = r_ptr[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ptr   = '0;
                    n_prio  = i_task_priority;
                    n_burst = i_task_burst;
                    if (i_func == FUNC_GRANT) begin
                        n_state = S_G1_CHK;
                    end else if (r_count != MAX_CNT) begin
                        n_state = S_LD_CHK;
                    end
                end
            end
            // find the insert position: after every row of equal or higher priority
            S_LD_CHK: begin
                if (r_ptr == r_count) begin
                    n_pos   = r_ptr;
                    n_ptr   = r_count;
                    n_state = S_SH_CHK;
                end else begin
                    n_state = S_LD_CMP;
                end
            end
            S_LD_CMP: begin
                if (tbl_rd_data.prio >= r_prio) begin
                    n_ptr   = ptr_inc;
                    n_state = S_LD_CHK;
                end else begin
                    n_pos   = r_ptr;
                    n_ptr   = r_count;
                    n_state = S_SH_CHK;
                end
            end
            // move rows down by one, from the end back to the insert position
            S_SH_CHK: begin
                tbl_rd_addr = ptr_dec[IW-1:0];
                if (r_ptr == r_pos) begin
                    n_state = S_LD_PUT;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = r_ptr[IW-1:0];
                tbl_wr_data = tbl_rd_data;
                n_ptr       = ptr_dec;
                n_state     = S_SH_CHK;
            end
            S_LD_PUT: begin
                tbl_wr_en           = 1'b1;
                tbl_wr_addr         = r_pos[IW-1:0];
                tbl_wr_data.prio    = r_prio;
                tbl_wr_data.burst   = r_burst;
                tbl_wr_data.load_id = ID_W'(r_count);
                if (r_pos < cursor_ext) begin
                    n_cursor = r_cursor + 1'b1;
                end
                n_count = r_count + 1'b1;
                n_state = S_IDLE;
            end
            // first row with work, tracking where its priority run begins
            S_G1_CHK: begin
                if (r_ptr == r_count) begin
                    n_out_valid = 1'b1;
                    n_out_id    = '0;
                    n_out_time  = '0;
                    n_out_slice = '0;
                    n_out_fin   = 1'b0;
                    n_out_done  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_G1_CMP;
                end
            end
            S_G1_CMP: begin
                n_gs   = run_start;
                n_prio = tbl_rd_data.prio;
                n_ptr  = ptr_inc;
                if (tbl_rd_data.burst != '0) begin
                    n_state = S_G2_CHK;
                end else begin
                    n_state = S_G1_CHK;
                end
            end
            // end of the group
            S_G2_CHK: begin
                if (r_ptr == r_count) begin
                    n_ge    = r_ptr;
                    n_ptr   = rr_start;
                    n_state = S_G3_RD;
                end else begin
                    n_state = S_G2_CMP;
                end
            end
            S_G2_CMP: begin
                if (tbl_rd_data.prio == r_prio) begin
                    n_ptr   = ptr_inc;
                    n_state = S_G2_CHK;
                end else begin
                    n_ge    = r_ptr;
                    n_ptr   = rr_start;
                    n_state = S_G3_RD;
                end
            end
            // round robin inside the group; a row with work is sure to be found
            S_G3_RD: begin
                n_state = S_G3_CMP;
            end
            S_G3_CMP: begin
                if (tbl_rd_data.burst != '0) begin
                    tbl_wr_en         = 1'b1;
                    tbl_wr_addr       = r_ptr[IW-1:0];
                    tbl_wr_data.burst = tbl_rd_data.burst - slice;
                    n_out_valid       = 1'b1;
                    n_out_id          = tbl_rd_data.load_id;
                    n_out_time        = r_elapsed;
                    n_out_slice       = slice;
                    n_out_fin         = (tbl_rd_data.burst == slice);
                    n_out_done        = 1'b0;
                    n_elapsed         = r_elapsed + TIME_W'(slice);
                    n_cursor          = (ptr_inc < r_count) ? ptr_inc[IW-1:0] : '0;
                    n_state           = S_IDLE;
                end else begin
                    n_ptr   = (ptr_inc == r_ge) ? r_gs : ptr_inc;
                    n_state = S_G3_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quantum   <= QUANTUM_RESET;
            r_count     <= '0;
            r_cursor    <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
            if (cfg_wr && paddr[2] == REG_QUANTUM) begin
                r_quantum <= pwdata[QUANT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_pos       <= n_pos;
        r_gs        <= n_gs;
        r_ge        <= n_ge;
        r_prio      <= n_prio;
        r_burst     <= n_burst;
        r_out_id    <= n_out_id;
        r_out_time  <= n_out_time;
        r_out_slice <= n_out_slice;
        r_out_fin   <= n_out_fin;
        r_out_done  <= n_out_done;
    end

    assign o_result_valid  = r_out_valid;
    assign o_task_id       = r_out_id;
    assign o_start_time    = r_out_time;
    assign o_slice_length  = r_out_slice;
    assign o_task_finished = r_out_fin;
    assign o_all_done      = r_out_done;

`ifndef SYNTH
    // a word is strobed only as the sequencer returns to idle
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobed while busy");

    // a load never produces a result word
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_LOAD) |=> !o_result_valid)
        else $error("result after a load");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("task count beyond capacity");

    // cursor always names a row in the table or is parked at zero
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor == '0) || (cursor_ext < r_count))
        else $error("cursor outside the table");

    a_finish_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_task_finished) |-> (o_slice_length != '0 && !o_all_done))
        else $error("task finished on an empty slice");
`endif

endmodule
